// ===== src/pps_pkg.sv =====
// Shared types, widths and codes for the preemptive priority scheduler.
// No dependencies; all RTL but pps_ram uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  localparam int OP_W   = 2;
  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int STAT_W = 3;
  localparam int JOB_W  = 5;
  localparam int TIME_W = 24;
  localparam int DONE_W = 5;
  localparam int SUM_W  = 28;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_RAN     = 3'd0;
  localparam logic [STAT_W-1:0] ST_IDLE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_LOADED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD     = 3'd5;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [DONE_W-1:0] DONE_MAX = '1;

  // One job table entry, kept as a single RAM word.
  typedef struct packed {
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRI_W-1:0] pri;
    logic [BUR_W-1:0] rem;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic load;
    logic clear;
    logic scan;
    logic run;
    logic wcalc;
    logic accum;
    logic emit;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic out_free;
  } sts_t;

  // One result item.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [JOB_W-1:0]  job_number;
    logic              job_finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [DONE_W-1:0] jobs_done;
    logic [SUM_W-1:0]  turnaround_sum;
    logic [SUM_W-1:0]  waiting_sum;
    logic [TIME_W-1:0] now;
  } res_t;

endpackage
`default_nettype wire

// ===== src/pps_req_if.sv =====
// Request channel of the scheduler: valid/ready plus the request fields.
// Depends on pps_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface pps_req_if;
  logic                         valid;
  logic                         ready;
  logic [pps_pkg::OP_W-1:0]     operation;
  logic [pps_pkg::ARR_W-1:0]    arrival_time;
  logic [pps_pkg::BUR_W-1:0]    burst_length;
  logic [pps_pkg::PRI_W-1:0]    job_priority;

  modport source (output valid, operation, arrival_time, burst_length, job_priority,
                  input ready);
  modport sink   (input valid, operation, arrival_time, burst_length, job_priority,
                  output ready);
endinterface
`default_nettype wire

// ===== src/pps_rsp_if.sv =====
// Result channel of the scheduler: valid/ready plus the result fields.
// Depends on pps_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface pps_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pps_pkg::STAT_W-1:0]    status;
  logic [pps_pkg::JOB_W-1:0]     job_number;
  logic                          job_finished;
  logic [pps_pkg::TIME_W-1:0]    finish_time;
  logic [pps_pkg::TIME_W-1:0]    turnaround;
  logic [pps_pkg::TIME_W-1:0]    waiting;
  logic [pps_pkg::DONE_W-1:0]    jobs_done;
  logic [pps_pkg::SUM_W-1:0]     turnaround_sum;
  logic [pps_pkg::SUM_W-1:0]     waiting_sum;
  logic [pps_pkg::TIME_W-1:0]    now;

  modport source (output valid, status, job_number, job_finished, finish_time,
                  turnaround, waiting, jobs_done, turnaround_sum, waiting_sum, now,
                  input ready);
  modport sink   (input valid, status, job_number, job_finished, finish_time,
                  turnaround, waiting, jobs_done, turnaround_sum, waiting_sum, now,
                  output ready);
endinterface
`default_nettype wire

// ===== src/pps_ram.sv =====
// Generic single-port RAM, write and registered read on one address.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                            wdata,
  output      logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== src/pps_ctrl.sv =====
// Sequencer of the scheduler: decodes requests and steps the datapath.
// Depends on pps_pkg (cmd_t, sts_t, op codes).
`timescale 1ns / 1ps
`default_nettype none
module pps_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  input  wire logic [pps_pkg::OP_W-1:0] req_op,
  output      logic                     req_ready,
  input  wire pps_pkg::sts_t            sts,
  output      pps_pkg::cmd_t            cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_RUN   = 4'd5;
  localparam logic [3:0] S_WCALC = 4'd6;
  localparam logic [3:0] S_ACCUM = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          unique case (req_op)
            pps_pkg::OP_LOAD:  state_next = S_LOAD;
            pps_pkg::OP_CLEAR: state_next = S_CLEAR;
            pps_pkg::OP_TICK:  state_next = sts.count_zero ? S_RUN : S_SCAN;
            default:           state_next = S_IDLE;  // unused op: dropped
          endcase
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_EMIT;
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = S_EMIT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_RUN;   // last read word is compared here
      S_RUN: begin
        cmd.run    = 1'b1;
        state_next = S_WCALC;
      end
      S_WCALC: begin
        cmd.wcalc  = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

// ===== src/pps_datapath.sv =====
// Datapath of the scheduler: job table RAM, scan compare, time and totals,
// result staging and the output register. Depends on pps_pkg and pps_ram.
`timescale 1ns / 1ps
`default_nettype none
module pps_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pps_pkg::cmd_t             cmd,
  output      pps_pkg::sts_t             sts,
  input  wire logic [pps_pkg::ARR_W-1:0] req_arr,
  input  wire logic [pps_pkg::BUR_W-1:0] req_bur,
  input  wire logic [pps_pkg::PRI_W-1:0] req_pri,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      pps_pkg::res_t             out_res
);
  localparam int IDX_W  = pps_pkg::IDX_W;
  localparam int CNT_W  = pps_pkg::CNT_W;
  localparam int TIME_W = pps_pkg::TIME_W;
  localparam int SUM_W  = pps_pkg::SUM_W;
  localparam int JOB_W  = pps_pkg::JOB_W;

  // latched request
  logic [pps_pkg::ARR_W-1:0] arr_q;
  logic [pps_pkg::BUR_W-1:0] bur_q;
  logic [pps_pkg::PRI_W-1:0] pri_q;

  // architectural state
  logic [CNT_W-1:0]          job_count;
  logic [TIME_W-1:0]         time_now;
  logic [pps_pkg::DONE_W-1:0] done_count;
  logic [SUM_W-1:0]          tat_total;
  logic [SUM_W-1:0]          wt_total;

  // scan and best candidate
  logic [IDX_W-1:0]          scan_idx;
  logic [IDX_W-1:0]          cmp_idx;
  logic                      cmp_valid;
  logic                      found;
  logic [IDX_W-1:0]          best_idx;
  pps_pkg::entry_t           best;

  // staged result fields
  logic [pps_pkg::STAT_W-1:0] res_status;
  logic [JOB_W-1:0]           res_job;
  logic                       res_fin;
  logic [TIME_W-1:0]          res_ftime;
  logic [TIME_W-1:0]          res_tat;
  logic [TIME_W-1:0]          res_wt;

  // RAM port
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_addr;
  pps_pkg::entry_t           ram_wdata;
  logic [pps_pkg::ENTRY_W-1:0] ram_rdata;
  pps_pkg::entry_t           rd;

  logic                      load_ok;
  logic                      elig;
  logic                      better;
  logic [TIME_W-1:0]         time_inc;
  logic [pps_pkg::BUR_W-1:0] rem_dec;
  logic                      fin_now;
  logic [SUM_W:0]            tat_sum_raw;
  logic [SUM_W:0]            wt_sum_raw;

  pps_ram #(
    .WIDTH (pps_pkg::ENTRY_W),
    .DEPTH (pps_pkg::MAX_JOBS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd      = pps_pkg::entry_t'(ram_rdata);
  assign load_ok = (bur_q != '0) && (job_count < CNT_W'(pps_pkg::MAX_JOBS));

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = scan_idx;
    ram_wdata = best;
    ram_wdata.rem = rem_dec;
    if (cmd.load) begin
      ram_we    = load_ok;
      ram_addr  = job_count[IDX_W-1:0];
      ram_wdata = '{arr: arr_q, bur: bur_q, pri: pri_q, rem: bur_q};
    end else if (cmd.run) begin
      ram_we   = found;
      ram_addr = best_idx;
    end
  end

  // candidate check on the word read last cycle
  assign elig   = ({{(TIME_W-pps_pkg::ARR_W){1'b0}}, rd.arr} <= time_now) && (rd.rem != '0);
  assign better = !found || (rd.pri < best.pri) ||
                  ((rd.pri == best.pri) && (rd.arr < best.arr));

  assign time_inc = (time_now == pps_pkg::TIME_MAX) ? time_now : time_now + 1'b1;
  assign rem_dec  = best.rem - 1'b1;
  assign fin_now  = (rem_dec == '0);

  assign tat_sum_raw = {1'b0, tat_total} + (SUM_W+1)'(res_tat);
  assign wt_sum_raw  = {1'b0, wt_total}  + (SUM_W+1)'(res_wt);

  assign sts.count_zero = (job_count == '0);
  assign sts.scan_last  = ((CNT_W'(scan_idx) + 1'b1) == job_count);
  assign sts.out_free   = !out_valid || out_ready;

  // request latch, scan and candidate tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      found     <= 1'b0;
      scan_idx  <= '0;
    end else begin
      cmp_valid <= cmd.scan;
      if (cmd.accept) begin
        found    <= 1'b0;
        scan_idx <= '0;
      end else if (cmd.scan) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmp_valid && elig && better) begin
        found <= 1'b1;
      end
    end
    if (cmd.accept) begin
      arr_q <= req_arr;
      bur_q <= req_bur;
      pri_q <= req_pri;
    end
    cmp_idx <= scan_idx;
    if (cmp_valid && elig && better) begin
      best     <= rd;
      best_idx <= cmp_idx;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      job_count  <= '0;
      time_now   <= '0;
      done_count <= '0;
      tat_total  <= '0;
      wt_total   <= '0;
    end else begin
      if (cmd.clear) begin
        job_count  <= '0;
        time_now   <= '0;
        done_count <= '0;
        tat_total  <= '0;
        wt_total   <= '0;
      end
      if (cmd.load && load_ok) begin
        job_count <= job_count + 1'b1;
      end
      if (cmd.run) begin
        time_now <= time_inc;
        if (found && fin_now && (done_count != pps_pkg::DONE_MAX)) begin
          done_count <= done_count + 1'b1;
        end
      end
      if (cmd.accum && res_fin) begin
        tat_total <= tat_sum_raw[SUM_W] ? '1 : tat_sum_raw[SUM_W-1:0];
        wt_total  <= wt_sum_raw[SUM_W]  ? '1 : wt_sum_raw[SUM_W-1:0];
      end
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_fin   <= 1'b0;
      res_ftime <= '0;
      res_tat   <= '0;
      res_wt    <= '0;
      if (bur_q == '0) begin
        res_status <= pps_pkg::ST_BAD;
        res_job    <= '0;
      end else if (!load_ok) begin
        res_status <= pps_pkg::ST_FULL;
        res_job    <= '0;
      end else begin
        res_status <= pps_pkg::ST_LOADED;
        res_job    <= JOB_W'(job_count + 1'b1);
      end
    end
    if (cmd.clear) begin
      res_status <= pps_pkg::ST_CLEARED;
      res_job    <= '0;
      res_fin    <= 1'b0;
      res_ftime  <= '0;
      res_tat    <= '0;
      res_wt     <= '0;
    end
    if (cmd.run) begin
      res_wt <= '0;
      if (found) begin
        res_status <= pps_pkg::ST_RAN;
        res_job    <= JOB_W'(best_idx) + 1'b1;
        res_fin    <= fin_now;
        res_ftime  <= fin_now ? time_inc : '0;
        res_tat    <= fin_now ?
                      time_inc - {{(TIME_W-pps_pkg::ARR_W){1'b0}}, best.arr} : '0;
      end else begin
        res_status <= pps_pkg::ST_IDLE;
        res_job    <= '0;
        res_fin    <= 1'b0;
        res_ftime  <= '0;
        res_tat    <= '0;
      end
    end
    if (cmd.wcalc) begin
      if (res_fin && (res_tat >= {{(TIME_W-pps_pkg::BUR_W){1'b0}}, best.bur})) begin
        res_wt <= res_tat - {{(TIME_W-pps_pkg::BUR_W){1'b0}}, best.bur};
      end else begin
        res_wt <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_res <= '{status:         res_status,
                   job_number:     res_job,
                   job_finished:   res_fin,
                   finish_time:    res_ftime,
                   turnaround:     res_tat,
                   waiting:        res_wt,
                   jobs_done:      done_count,
                   turnaround_sum: tat_total,
                   waiting_sum:    wt_total,
                   now:            time_now};
    end
  end
endmodule
`default_nettype wire

// ===== src/preemptive_priority_scheduler_top.sv =====
// Top level of the preemptive priority scheduler: controller, datapath and
// the channel interfaces. Depends on pps_pkg, pps_req_if, pps_rsp_if,
// pps_ctrl and pps_datapath.
//
// Usage:
//   req carries one request: load a job, advance time by one unit, or clear
//   the table, time and totals. Operation code 3 is accepted and dropped.
//   rsp carries exactly one result for each load, tick or clear.
//   Handshake on both channels: a transfer happens on a rising clk edge with
//   valid and ready high.
// Sequencing (req.ready is high only while the controller is idle):
//   load, clear: the result is staged in the datapath, then registered in
//     the output register; the next request is taken after that.
//   tick: the job table is a single-port RAM read one entry per cycle; the
//     scan reads each of the N jobs in it (16 when the table is full),
//     a drain state compares the last word read, and the tail is update,
//     waiting-time calc, totals, and emit.
//   With an empty table a tick skips the scan and the drain state.
// Stalls:
//   rsp has a single output register. The next request is taken while a
//   result waits; that request's result is held back in the datapath until
//   the register frees, and req.ready stays low meanwhile.
// Reset (rst, synchronous, active high): job count, time, completion count
//   and totals go to zero; the table contents are not cleared and are never
//   read before being written.
`timescale 1ns / 1ps
`default_nettype none
module preemptive_priority_scheduler_top (
  input  wire logic    clk,
  input  wire logic    rst,
  pps_req_if.sink      req,
  pps_rsp_if.source    rsp
);
  pps_pkg::cmd_t cmd;
  pps_pkg::sts_t sts;
  pps_pkg::res_t out_res;
  logic          ctrl_ready;

  // request decode and sequencing
  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.operation),
    .req_ready (ctrl_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  assign req.ready = ctrl_ready;

  // table, arithmetic and result register
  pps_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_arr   (req.arrival_time),
    .req_bur   (req.burst_length),
    .req_pri   (req.job_priority),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_res   (out_res)
  );

  assign rsp.status         = out_res.status;
  assign rsp.job_number     = out_res.job_number;
  assign rsp.job_finished   = out_res.job_finished;
  assign rsp.finish_time    = out_res.finish_time;
  assign rsp.turnaround     = out_res.turnaround;
  assign rsp.waiting        = out_res.waiting;
  assign rsp.jobs_done      = out_res.jobs_done;
  assign rsp.turnaround_sum = out_res.turnaround_sum;
  assign rsp.waiting_sum    = out_res.waiting_sum;
  assign rsp.now            = out_res.now;
endmodule
`default_nettype wire

// ===== tb/preemptive_priority_scheduler_top_tb.sv =====
// Self-checking bench for preemptive_priority_scheduler_top: directed requests, then job sets
// with random content; results checked against the in-bench scheduler model or typed results.
// Depends on pps_pkg, pps_req_if, pps_rsp_if and the scheduler RTL.
`timescale 1ns / 1ps
module preemptive_priority_scheduler_top_tb;
  import pps_pkg::*;

  // Operation code 3 is accepted by the block and dropped without a result.
  localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
  localparam logic [SUM_W-1:0] SUM_CAP     = '1;
  localparam int               ITEM_TARGET = 1700;
  localparam int               CYCLE_LIMIT = 1_000_000;
  // The longest tick comes with a full table; give the tail some slack.
  localparam int               DRAIN_CYCLES = 60;
  localparam int               MAX_ERR_LINES = 100;

  logic clk = 1'b0;
  logic rst;

  pps_req_if req_ch ();
  pps_rsp_if rsp_ch ();

  preemptive_priority_scheduler_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler model: job table, clock and totals as the block should hold them.
  // ---------------------------------------------------------------------------
  logic [ARR_W-1:0]  tbl_arr [MAX_JOBS];
  logic [BUR_W-1:0]  tbl_bur [MAX_JOBS];
  logic [PRI_W-1:0]  tbl_pri [MAX_JOBS];
  logic [BUR_W-1:0]  tbl_rem [MAX_JOBS];
  int                tbl_count  = 0;
  logic [TIME_W-1:0] clock_now  = '0;
  logic [DONE_W-1:0] done_total = '0;
  logic [SUM_W-1:0]  tat_total  = '0;
  logic [SUM_W-1:0]  wait_total = '0;

  res_t pending_results [$];
  int   requests_sent = 0;
  int   fault_count   = 0;
  int   cycle_count   = 0;
  bit   no_gap_run    = 1'b0;

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [TIME_W-1:0] inc);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + inc;
    return s[SUM_W] ? SUM_CAP : s[SUM_W-1:0];
  endfunction

  // Applies one request to the model and returns the result it should produce.
  function automatic res_t schedule_step(logic [OP_W-1:0] op, logic [ARR_W-1:0] arr,
                                         logic [BUR_W-1:0] bur, logic [PRI_W-1:0] pri);
    res_t              r;
    int                pick;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    r    = '0;
    pick = -1;
    case (op)
      OP_LOAD: begin
        // zero burst is rejected ahead of the table-full check
        if (bur == '0) begin
          r.status = ST_BAD;
        end else if (tbl_count >= MAX_JOBS) begin
          r.status = ST_FULL;
        end else begin
          tbl_arr[tbl_count] = arr;
          tbl_bur[tbl_count] = bur;
          tbl_pri[tbl_count] = pri;
          tbl_rem[tbl_count] = bur;
          tbl_count++;
          r.status     = ST_LOADED;
          r.job_number = tbl_count;
        end
      end
      OP_TICK: begin
        // lowest priority value, then earliest arrival, then lowest index
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_arr[i] <= clock_now && tbl_rem[i] != '0) begin
            if (pick < 0 || tbl_pri[i] < tbl_pri[pick] ||
                (tbl_pri[i] == tbl_pri[pick] && tbl_arr[i] < tbl_arr[pick]))
              pick = i;
          end
        end
        if (clock_now != TIME_MAX) clock_now++;
        if (pick < 0) begin
          r.status = ST_IDLE;
        end else begin
          r.status     = ST_RAN;
          r.job_number = pick + 1;
          tbl_rem[pick]--;
          if (tbl_rem[pick] == '0) begin
            tat = clock_now - tbl_arr[pick];
            wt  = (tat >= tbl_bur[pick]) ? tat - tbl_bur[pick] : '0;
            r.job_finished = 1'b1;
            r.finish_time  = clock_now;
            r.turnaround   = tat;
            r.waiting      = wt;
            if (done_total != DONE_MAX) done_total++;
            tat_total  = sat_sum(tat_total, tat);
            wait_total = sat_sum(wait_total, wt);
          end
        end
      end
      OP_CLEAR: begin
        // table contents stay but are dead once the count is zero
        tbl_count  = 0;
        clock_now  = '0;
        done_total = '0;
        tat_total  = '0;
        wait_total = '0;
        r.status   = ST_CLEARED;
      end
      default: ;
    endcase
    r.jobs_done      = done_total;
    r.turnaround_sum = tat_total;
    r.waiting_sum    = wait_total;
    r.now            = clock_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Valid is only lowered when a gap follows, so a back-to-back
  // request never sees valid dropped and raised in the same step.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (no_gap_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // Drives one request and returns at the edge that accepts it. A typed result,
  // where given, replaces the model's prediction as the expectation.
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [ARR_W-1:0] arr,
                               input logic [BUR_W-1:0] bur, input logic [PRI_W-1:0] pri,
                               input bit typed = 1'b0, input res_t typed_res = '0);
    int   gap;
    res_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.arrival_time <= arr;
    req_ch.burst_length <= bur;
    req_ch.job_priority <= pri;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (op != OP_UNUSED) begin
      predicted = schedule_step(op, arr, bur, pri);
      pending_results.push_back(typed ? typed_res : predicted);
      requests_sent++;
    end
  endtask

  // Sprinkles dropped opcodes, rejected loads and stray loads into a job set.
  task automatic maybe_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)
      issue_request(OP_UNUSED, $urandom, $urandom, $urandom);
    else if (r < 7)
      issue_request(OP_LOAD, $urandom, '0, $urandom);
    else if (r < 8)
      issue_request(OP_LOAD, $urandom, $urandom_range(1, 65535), $urandom);
  endtask

  // One job set: clear, load jobs, then tick for their burst sum (bursts capped at 8)
  // plus up to 8 more, at most 90 ticks. Some sets overfill the table, some use only
  // four priority levels so the arrival and index tie-breaks get exercised.
  task automatic run_job_set();
    int               n_loads;
    int               n_ticks;
    int               burst_sum;
    bit               tight;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRI_W-1:0] pri;
    no_gap_run = ($urandom_range(0, 5) == 0);
    tight      = $urandom_range(0, 1);
    burst_sum  = 0;
    n_loads    = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 19)
                                             : $urandom_range(1, 16);
    issue_request(OP_CLEAR, $urandom, $urandom, $urandom);
    for (int k = 0; k < n_loads; k++) begin
      maybe_noise();
      arr = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 24);
      bur = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 6);
      pri = tight ? $urandom_range(0, 3) : $urandom_range(0, 255);
      burst_sum += (bur > 8) ? 8 : bur;
      issue_request(OP_LOAD, arr, bur, pri);
    end
    n_ticks = burst_sum + $urandom_range(0, 8);
    if (n_ticks > 90) n_ticks = 90;
    for (int k = 0; k < n_ticks; k++) begin
      maybe_noise();
      // late arrival during the run can preempt the running job
      if ($urandom_range(0, 14) == 0)
        issue_request(OP_LOAD, clock_now[ARR_W-1:0] + $urandom_range(0, 6),
                      $urandom_range(1, 5), tight ? $urandom_range(0, 3) : $urandom);
      issue_request(OP_TICK, $urandom, $urandom, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Typed rows carry status, job and time; the other result
  // fields are zero there (nothing has completed yet).
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRI_W-1:0] pri;
    bit               typed;
    res_t             want;
  } stim_row_t;

  function automatic stim_row_t mk_row(logic [OP_W-1:0] op, logic [ARR_W-1:0] arr,
                                       logic [BUR_W-1:0] bur, logic [PRI_W-1:0] pri,
                                       bit typed = 1'b0, logic [STAT_W-1:0] st = '0,
                                       logic [JOB_W-1:0] job = '0,
                                       logic [TIME_W-1:0] at = '0);
    stim_row_t s;
    s.op              = op;
    s.arr             = arr;
    s.bur             = bur;
    s.pri             = pri;
    s.typed           = typed;
    s.want            = '0;
    s.want.status     = st;
    s.want.job_number = job;
    s.want.now        = at;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pacing and the field-by-field check.
  // ---------------------------------------------------------------------------
  initial begin : sink_pacing
    int r;
    int hold;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      rsp_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      // now and then a long stretch with no back-pressure at all
      repeat ((r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 20)) @(posedge clk);
      r = $urandom_range(0, 99);
      hold = (r < 60) ? $urandom_range(1, 3) :
             (r < 95) ? $urandom_range(4, 10) : $urandom_range(25, 60);
      rsp_ch.ready <= 1'b0;
      repeat (hold) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      fault_count++;
      if (fault_count <= MAX_ERR_LINES)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_ERR_LINES)
          $display("%0t: unexpected result, expected none, got status %0d job %0d",
                   $time, rsp_ch.status, rsp_ch.job_number);
      end else begin
        want = pending_results.pop_front();
        check_field("status",         want.status,         rsp_ch.status);
        check_field("job_number",     want.job_number,     rsp_ch.job_number);
        check_field("job_finished",   want.job_finished,   rsp_ch.job_finished);
        check_field("finish_time",    want.finish_time,    rsp_ch.finish_time);
        check_field("turnaround",     want.turnaround,     rsp_ch.turnaround);
        check_field("waiting",        want.waiting,        rsp_ch.waiting);
        check_field("jobs_done",      want.jobs_done,      rsp_ch.jobs_done);
        check_field("turnaround_sum", want.turnaround_sum, rsp_ch.turnaround_sum);
        check_field("waiting_sum",    want.waiting_sum,    rsp_ch.waiting_sum);
        check_field("now",            want.now,            rsp_ch.now);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("preemptive_priority_scheduler_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t rows [$];
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.operation    <= OP_LOAD;
    req_ch.arrival_time <= '0;
    req_ch.burst_length <= '0;
    req_ch.job_priority <= '0;

    // tick on an empty table right out of reset, then the dropped opcode
    rows.push_back(mk_row(OP_TICK, 16'h0000, 16'h0000, 8'h00, 1'b1, ST_IDLE, 0, 1));
    rows.push_back(mk_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF));
    rows.push_back(mk_row(OP_LOAD, 16'hFFFF, 16'h0000, 8'hFF, 1'b1, ST_BAD, 0, 1));
    rows.push_back(mk_row(OP_CLEAR, 16'h0000, 16'h0000, 8'h00, 1'b1, ST_CLEARED, 0, 0));
    // jobs 1 and 2 tie on priority and arrival; job 3 arrives later but wins
    // on priority; job 4 never arrives; job 5 has the worst priority
    rows.push_back(mk_row(OP_LOAD, 16'd0, 16'd3, 8'd5, 1'b1, ST_LOADED, 1, 0));
    rows.push_back(mk_row(OP_LOAD, 16'd0, 16'd1, 8'd5, 1'b1, ST_LOADED, 2, 0));
    rows.push_back(mk_row(OP_LOAD, 16'd1, 16'd2, 8'd0, 1'b1, ST_LOADED, 3, 0));
    rows.push_back(mk_row(OP_LOAD, 16'hFFFF, 16'hFFFF, 8'd0, 1'b1, ST_LOADED, 4, 0));
    rows.push_back(mk_row(OP_LOAD, 16'd0, 16'd1, 8'hFF, 1'b1, ST_LOADED, 5, 0));
    repeat (3) rows.push_back(mk_row(OP_TICK, 16'h0000, 16'h0000, 8'h00));
    // fill the table; same priority as job 1, arrivals falling with index
    for (int k = 6; k <= MAX_JOBS; k++)
      rows.push_back(mk_row(OP_LOAD, 16'(MAX_JOBS - k), 16'(k), 8'd5));
    rows.push_back(mk_row(OP_LOAD, 16'd2, 16'd4, 8'd1));   // table full
    rows.push_back(mk_row(OP_LOAD, 16'd2, 16'd0, 8'd1));   // zero burst wins over full
    rows.push_back(mk_row(OP_TICK, 16'h0000, 16'h0000, 8'h00));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      issue_request(rows[i].op, rows[i].arr, rows[i].bur, rows[i].pri,
                    rows[i].typed, rows[i].want);

    while (requests_sent < ITEM_TARGET) run_job_set();
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0)
      $display("preemptive_priority_scheduler_top regression: pass");
    else
      $display("preemptive_priority_scheduler_top regression: fail");
    $finish;
  end

endmodule
